[design/swm_pkg.sv]
package swm_pkg;

   // Payload widths fixed by the sample format
   localparam int SAMPLE_W = 32;
   localparam int RESULT_W = 33;
   localparam int SIZE_W   = 6;

   // Window size after reset
   localparam int SIZE_RESET = 3;

   // Default depth of the window storage
   localparam int WINDOW_MAX_DEFAULT = 32;

   // Operation applied to every sorted cell in the same cycle
   typedef struct packed {
      logic clear;   // drop all occupancy
      logic remove;  // take out one copy of the key, close the gap
      logic insert;  // open a gap at the key's position and place it
   } cell_ctrl_type;

endpackage

[design/swm_if.sv]
// Sample channel
interface swm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [swm_pkg::SAMPLE_W-1:0] sample;
   logic                                restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

// Result channel
interface swm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [swm_pkg::RESULT_W-1:0] median_doubled;

   modport source (output valid, output median_doubled, input ready);
   modport sink   (input valid, input median_doubled, output ready);
endinterface

[design/swm_ram.sv]
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/swm_cell.sv]
// One position of the sorted window. Besides the shared key and operation, talks only to its two neighbors.
module swm_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  swm_pkg::cell_ctrl_type              ctrl,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] key,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] left_val,
   input  logic                                left_occ,
   input  logic                                left_greater,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] right_val,
   input  logic                                right_occ,
   output logic signed [swm_pkg::SAMPLE_W-1:0] val,
   output logic                                occ,
   output logic                                greater
);

   logic signed [swm_pkg::SAMPLE_W-1:0] val_ff, val_in;
   logic                                occ_ff, occ_in;
   logic                                not_less;

   assign greater  = occ_ff && (val_ff > key);
   assign not_less = occ_ff && (val_ff >= key);

   // Next value: clear, shift left on removal, shift right on insertion
   always_comb begin
      val_in = val_ff;
      occ_in = occ_ff;
      if (ctrl.clear) begin
         occ_in = 1'b0;
      end else if (ctrl.remove && not_less) begin
         // every cell from the first copy of the key upward pulls its right neighbor
         val_in = right_val;
         occ_in = right_occ;
      end else if (ctrl.insert && (greater || (!occ_ff && left_occ))) begin
         // first larger or first empty cell takes the key, the rest pull from the left
         val_in = left_greater ? left_val : key;
         occ_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign occ = occ_ff;

endmodule

[design/sliding_window_median_core.sv]
// Streaming median filter over the last window_size signed 32-bit samples
// (1 to WINDOW_MAX; 0 acts as 1, larger values saturate). Each result is the
// sum of the two middle values of the sorted window, i.e. the median with one
// fractional bit. The window is kept sorted in a chain of compare-and-shift
// cells and in arrival order in a ring RAM. A sample is accepted, inserted by a
// pass through the cell chain, and the middle values are added before the next
// is taken; once the window is full, an extra chain pass first removes the oldest
// sample read from the ring RAM. A waiting result does not block the next sample;
// a second result waits only if the first has not been taken by then. A write
// of csr_wdata, or a sample with restart set, empties the window, and the first
// window_size-1 samples after that give no result. No clearing pass after reset.
module sliding_window_median_core #(
   parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   swm_req_if.sink                    req_port,
   swm_rsp_if.source                  rsp_port,
   input  logic                       csr_we,
   input  logic [swm_pkg::SIZE_W-1:0] csr_wdata
);

   localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int EXT_W     = (CNT_W > swm_pkg::SIZE_W) ? CNT_W : swm_pkg::SIZE_W;
   localparam int RESET_W   = (swm_pkg::SIZE_RESET > WINDOW_MAX) ?
                              WINDOW_MAX : swm_pkg::SIZE_RESET;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_SUM
   } state_type;

   state_type                           state_ff;
   logic [CNT_W-1:0]                    eff_w_ff;
   logic [CNT_W-1:0]                    fill_ff;
   logic [PTR_W-1:0]                    oldest_ff;
   logic [PTR_W-1:0]                    wr_addr_ff;
   logic                                full_ff;
   logic                                emit_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                rsp_valid_ff;
   logic signed [swm_pkg::RESULT_W-1:0] rsp_data_ff;

   logic                                req_xfer;
   logic                                rsp_load;
   logic                                full_now;
   logic [EXT_W-1:0]                    wdata_ext;
   logic [CNT_W-1:0]                    eff_w_in;
   logic [CNT_W-1:0]                    oldest_inc;
   logic [CNT_W-1:0]                    mid_lo_idx;
   logic [CNT_W-1:0]                    mid_hi_idx;
   logic signed [swm_pkg::SAMPLE_W-1:0] mid_lo_val;
   logic signed [swm_pkg::SAMPLE_W-1:0] mid_hi_val;
   logic signed [swm_pkg::RESULT_W-1:0] mid_sum;
   logic signed [swm_pkg::SAMPLE_W-1:0] ring_rd_data;
   logic signed [swm_pkg::SAMPLE_W-1:0] cell_key;
   swm_pkg::cell_ctrl_type              cell_ctrl;

   logic signed [swm_pkg::SAMPLE_W-1:0] cell_val [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]               cell_occ;
   logic [WINDOW_MAX-1:0]               cell_greater;

   // Handshake
   assign req_port.ready          = (state_ff == ST_IDLE);
   assign req_xfer                = req_port.valid && req_port.ready;
   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.median_doubled = rsp_data_ff;

   // Result register takes a new sum once it is free or being drained
   assign rsp_load = (state_ff == ST_SUM) && emit_ff && (!rsp_valid_ff || rsp_port.ready);

   // Effective window size from the register write: 0 -> 1, saturate at max
   assign wdata_ext = EXT_W'(csr_wdata);
   always_comb begin
      if (csr_wdata == '0) begin
         eff_w_in = CNT_W'(1);
      end else if (wdata_ext > EXT_W'(WINDOW_MAX)) begin
         eff_w_in = CNT_W'(WINDOW_MAX);
      end else begin
         eff_w_in = wdata_ext[CNT_W-1:0];
      end
   end

   assign full_now   = !req_port.restart && (fill_ff >= eff_w_ff);
   assign oldest_inc = CNT_W'(oldest_ff) + CNT_W'(1);

   // Ring of samples in arrival order
   swm_ram #(
      .WIDTH (swm_pkg::SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_INSERT),
      .wr_addr (wr_addr_ff),
      .wr_data (sample_ff),
      .rd_addr (oldest_ff),
      .rd_data (ring_rd_data)
   );

   // Chain operation for this cycle
   always_comb begin
      cell_ctrl.clear  = csr_we || (req_xfer && req_port.restart);
      cell_ctrl.remove = (state_ff == ST_REMOVE);
      cell_ctrl.insert = (state_ff == ST_INSERT);
   end
   assign cell_key = (state_ff == ST_REMOVE) ? ring_rd_data : sample_ff;

   // Sorted cell chain
   for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
      logic signed [swm_pkg::SAMPLE_W-1:0] left_val;
      logic                                left_occ;
      logic                                left_greater;
      logic signed [swm_pkg::SAMPLE_W-1:0] right_val;
      logic                                right_occ;

      if (j == 0) begin : g_first
         assign left_val     = cell_key;
         assign left_occ     = 1'b1;
         assign left_greater = 1'b0;
      end else begin : g_inner_left
         assign left_val     = cell_val[j-1];
         assign left_occ     = cell_occ[j-1];
         assign left_greater = cell_greater[j-1];
      end

      if (j == WINDOW_MAX - 1) begin : g_last
         assign right_val = cell_key;
         assign right_occ = 1'b0;
      end else begin : g_inner_right
         assign right_val = cell_val[j+1];
         assign right_occ = cell_occ[j+1];
      end

      swm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .key          (cell_key),
         .left_val     (left_val),
         .left_occ     (left_occ),
         .left_greater (left_greater),
         .right_val    (right_val),
         .right_occ    (right_occ),
         .val          (cell_val[j]),
         .occ          (cell_occ[j]),
         .greater      (cell_greater[j])
      );
   end

   // Pick the two middle cells and add them
   assign mid_lo_idx = (eff_w_ff - CNT_W'(1)) >> 1;
   assign mid_hi_idx = eff_w_ff >> 1;
   always_comb begin
      mid_lo_val = '0;
      mid_hi_val = '0;
      for (int j = 0; j < WINDOW_MAX; j++) begin
         if (mid_lo_idx == CNT_W'(j)) begin
            mid_lo_val = mid_lo_val | cell_val[j];
         end
         if (mid_hi_idx == CNT_W'(j)) begin
            mid_hi_val = mid_hi_val | cell_val[j];
         end
      end
   end
   assign mid_sum = {mid_lo_val[swm_pkg::SAMPLE_W-1], mid_lo_val} +
                    {mid_hi_val[swm_pkg::SAMPLE_W-1], mid_hi_val};

   // Ring slot for the new sample: oldest when full, slot 0 after a restart
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff <= req_port.sample;
         if (full_now) begin
            wr_addr_ff <= oldest_ff;
         end else if (req_port.restart) begin
            wr_addr_ff <= '0;
         end else begin
            wr_addr_ff <= fill_ff[PTR_W-1:0];
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= mid_sum;
      end
   end

   // Sequencer, window bookkeeping and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eff_w_ff     <= CNT_W'(RESET_W);
         fill_ff      <= '0;
         oldest_ff    <= '0;
         full_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            eff_w_ff  <= eff_w_in;
            fill_ff   <= '0;
            oldest_ff <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  full_ff <= full_now;
                  if (req_port.restart) begin
                     fill_ff   <= '0;
                     oldest_ff <= '0;
                  end
                  state_ff <= full_now ? ST_REMOVE : ST_INSERT;
               end
            end
            ST_REMOVE: begin
               fill_ff  <= fill_ff - CNT_W'(1);
               state_ff <= ST_INSERT;
            end
            ST_INSERT: begin
               fill_ff <= fill_ff + CNT_W'(1);
               emit_ff <= ((fill_ff + CNT_W'(1)) == eff_w_ff);
               if (full_ff) begin
                  oldest_ff <= (oldest_inc == eff_w_ff) ? '0 : oldest_inc[PTR_W-1:0];
               end
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (!emit_ff || rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Window never holds more samples than its size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_w_ff)
      else $error("fill count above window size");

   // Occupied cells match the fill count
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_occ) == int'(fill_ff))
      else $error("occupied cells differ from fill count");

   // Occupied cells form a contiguous run from cell zero
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      (cell_occ & (cell_occ + WINDOW_MAX'(1))) == '0)
      else $error("gap in occupied cells");

   // A new result comes only out of the sum step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SUM) && $past(emit_ff))
      else $error("result raised outside the sum step");

   // Oldest pointer stays inside the window
   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(oldest_ff) < eff_w_ff)
      else $error("oldest pointer outside window");

endmodule

[tb/tb_sliding_window_median_core.sv]
module tb_sliding_window_median_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     DEPTH       = swm_pkg::WINDOW_MAX_DEFAULT;
   localparam int     SIZE_W      = swm_pkg::SIZE_W;
   localparam int     LATENCY     = 4;
   localparam int     SETTLE      = 4 * LATENCY;
   localparam int     PHASE_ITEMS = 75;
   localparam int     HOLD_CYCLES = 300;
   localparam longint CYCLE_LIMIT = 200000;

   typedef logic signed [swm_pkg::SAMPLE_W-1:0] sample_type;
   typedef logic signed [swm_pkg::RESULT_W-1:0] median_type;
   typedef struct {
      sample_type sample;
      logic       restart;
   } sample_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;

   swm_req_if req_ch ();
   swm_rsp_if rsp_ch ();

   sliding_window_median_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and scoreboard storage
   sample_item_type pending[$];
   median_type      median_expected[$];
   sample_item_type next_item;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   logic            rx_hold        = 1'b0;
   int              mismatches     = 0;
   longint          cycle_count    = 0;

   // Window model: size register, arrival ring, ascending list
   logic [SIZE_W-1:0] win_size = SIZE_W'(swm_pkg::SIZE_RESET);
   sample_type        arrival[DEPTH];
   sample_type        ranked[DEPTH];
   int                fill   = 0;
   int                oldest = 0;

   // Clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_window();
      fill   = 0;
      oldest = 0;
   endfunction

   // Advance the window by one sample and queue the median it produces, if any
   function automatic void predict_sample(sample_type s, logic restart);
      int         w, p, i, j, pos;
      median_type median;
      w = (win_size == 0) ? 1 : (win_size > DEPTH) ? DEPTH : int'(win_size);
      if (restart) begin
         clear_window();
      end
      if (fill >= w) begin
         // full: drop one copy of the oldest sample, then overwrite its slot
         p = oldest % w;
         for (i = 0; i < fill; i++) begin
            if (ranked[i] == arrival[p]) begin
               for (j = i; j < fill - 1; j++) begin
                  ranked[j] = ranked[j + 1];
               end
               fill--;
               break;
            end
         end
         arrival[p] = s;
         oldest     = (p + 1) % w;
      end else begin
         arrival[fill] = s;
      end
      // insert after any equal values
      pos = 0;
      while (pos < fill && ranked[pos] <= s) begin
         pos++;
      end
      for (j = fill; j > pos; j--) begin
         ranked[j] = ranked[j - 1];
      end
      ranked[pos] = s;
      fill++;
      if (fill == w) begin
         median = median_type'(ranked[(w - 1) / 2]) + median_type'(ranked[w / 2]);
         median_expected = {median_expected, median};
      end
   endfunction

   // Mix of small values (duplicates), extremes and full-range samples
   function automatic sample_type rand_sample();
      case ($urandom_range(7))
         0, 1: begin
            return sample_type'(int'($urandom_range(6)) - 3);
         end
         2: begin
            return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         end
         default: begin
            return sample_type'($urandom());
         end
      endcase
   endfunction

   task automatic add_sample(sample_type s, logic restart);
      sample_item_type it;
      it.sample  = s;
      it.restart = restart;
      pending    = {pending, it};
   endtask

   task automatic add_random(int n, int restart_odds);
      @(negedge clock);
      repeat (n) begin
         add_sample(rand_sample(), $urandom_range(restart_odds - 1) == 0);
      end
   endtask

   // Block until nothing is queued, in flight or expected, then let it settle
   task automatic wait_idle();
      while (pending.size() != 0 || req_ch.valid || median_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_window(logic [SIZE_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      win_size = v;
      clear_window();
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // Driver: present the next pending sample once the current one transfers
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_sample(req_ch.sample, req_ch.restart);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.sample  <= next_item.sample;
               req_ch.restart <= next_item.restart;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest expected median
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (median_expected.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result %0d", rsp_ch.median_doubled);
               end
               mismatches++;
            end else if (rsp_ch.median_doubled !== median_expected[0]) begin
               if (mismatches < 10) begin
                  $display("median_doubled mismatch: expected %0d, got %0d",
                           median_expected[0], rsp_ch.median_doubled);
               end
               mismatches++;
               void'(median_expected.pop_front());
            end else begin
               void'(median_expected.pop_front());
            end
         end
         rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sequence: directed samples, then random phases over several window sizes
   initial begin
      logic [SIZE_W-1:0] sizes[10];
      int                ph;
      sizes = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd2, 6'd33, 6'd4, 6'd17, 6'd31, 6'd5};

      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.restart = 1'b0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, duplicates, restart, under the reset window size
      @(negedge clock);
      add_sample(32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sh8000_0000, 1'b0);
      add_sample(32'sh8000_0000, 1'b0);
      add_sample(32'sh8000_0000, 1'b0);
      add_sample(32'sh0000_0000, 1'b0);
      add_sample(-32'sd1, 1'b0);
      add_sample(32'sd1, 1'b0);
      add_sample(32'sd5, 1'b0);
      add_sample(32'sd5, 1'b0);
      add_sample(32'sd5, 1'b0);
      add_sample(-32'sd5, 1'b0);
      add_sample(32'sd5, 1'b0);
      add_sample(32'sd9, 1'b1);
      add_sample(32'sd9, 1'b0);
      add_sample(-32'sd9, 1'b0);
      add_sample(32'sh8000_0000, 1'b0);
      add_sample(32'sh7FFF_FFFF, 1'b1);
      add_sample(32'sh7FFF_FFFF, 1'b0);
      add_sample(32'sh8000_0000, 1'b0);
      add_sample(32'sh8000_0000, 1'b0);
      wait_idle();

      for (ph = 0; ph < 10; ph++) begin
         set_window(sizes[ph]);
         case (ph % 4)
            0: set_idling(0, 0);
            1: set_idling(75, 0);
            2: set_idling(0, 75);
            default: set_idling(10, 10);
         endcase
         if (ph == 4) begin
            // receiver holds off while the sender keeps offering samples
            add_random(PHASE_ITEMS, 40);
            fork
               begin
                  rx_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rx_hold <= 1'b0;
               end
            join_none
         end else if (ph == 6) begin
            // sender pauses until every result of the first half is in
            add_random(PHASE_ITEMS / 2, 40);
            wait_idle();
            add_random(PHASE_ITEMS - PHASE_ITEMS / 2, 40);
         end else begin
            add_random(PHASE_ITEMS, (sizes[ph] > 16) ? 200 : 40);
         end
         wait_idle();
      end

      if (median_expected.size() != 0) begin
         $display("%0d expected results never arrived", median_expected.size());
      end
      if (mismatches == 0 && median_expected.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sliding_window_median_core.f]
design/swm_pkg.sv
design/swm_if.sv
design/swm_ram.sv
design/swm_cell.sv
design/sliding_window_median_core.sv
tb/tb_sliding_window_median_core.sv
